[design/third_order_iir_tdf2_unit_macros.svh]
// Assertion macros shared by the checker of the third-order IIR unit.
// Depends on nothing; included by the checker file only.
`ifndef THIRD_ORDER_IIR_TDF2_UNIT_MACROS_SVH
`define THIRD_ORDER_IIR_TDF2_UNIT_MACROS_SVH

// same-cycle implication
`define IIRTDF_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IIRTDF_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/iirtdf_pkg.sv]
// Shared types, widths, microcode table and saturation helpers of the IIR unit.
// No dependencies; used by the sequencer, the top level and the checker.
package iirtdf_pkg;

   localparam int SAMPLE_W      = 24;
   localparam int COEF_W        = 32;
   localparam int DELAY_W       = 48;
   localparam int PROD_W        = COEF_W + SAMPLE_W;
   localparam int ACC_W         = DELAY_W + 2;
   localparam int DEF_ORDER     = 3;
   localparam int DEF_FRAC_BITS = 28;

   // microcode program addresses
   typedef enum logic [2:0] {
      ST_MUL0,
      ST_OUT,
      ST_LOOP_A,
      ST_LOOP_B,
      ST_IDLE
   } step_type;

   // which coefficient feeds the multiplier
   typedef enum logic [1:0] {
      CS_B0,
      CS_B_TAP,
      CS_B_NEXT,
      CS_A_TAP
   } coef_sel_type;

   // when a step may take a request
   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_ALWAYS,
      ACC_LAST_TAP
   } accept_type;

   // jump condition of a step
   typedef enum logic [1:0] {
      CD_NONE,
      CD_STALL,
      CD_MORE_TAPS
   } cond_type;

   typedef struct packed {
      coef_sel_type coef_sel;
      logic         mul_en;
      logic         mul_y;
      logic         y_load;
      logic         acc_load;
      logic         h_write;
   } dp_ctrl_type;

   typedef struct packed {
      dp_ctrl_type dp;
      accept_type  accept;
      logic        tap_clr;
      logic        tap_inc;
      cond_type    cond;
      step_type    jump_to;
      step_type    next_step;
   } ucode_type;

   // control store
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '0;
      w.accept    = ACC_NONE;
      w.cond      = CD_NONE;
      w.jump_to   = ST_IDLE;
      w.next_step = ST_IDLE;
      unique case (step)
         ST_MUL0: begin
            // b0 * s
            w.dp.coef_sel = CS_B0;
            w.dp.mul_en   = 1'b1;
            w.tap_clr     = 1'b1;
            w.next_step   = ST_OUT;
         end
         ST_OUT: begin
            // y = sat(h0 + b0*s), start b1 * s
            w.dp.coef_sel = CS_B_TAP;
            w.dp.mul_en   = 1'b1;
            w.dp.y_load   = 1'b1;
            w.cond        = CD_STALL;
            w.jump_to     = ST_OUT;
            w.next_step   = ST_LOOP_A;
         end
         ST_LOOP_A: begin
            // acc = h[i] + bi*s, start ai * y
            w.dp.coef_sel = CS_A_TAP;
            w.dp.mul_en   = 1'b1;
            w.dp.mul_y    = 1'b1;
            w.dp.acc_load = 1'b1;
            w.next_step   = ST_LOOP_B;
         end
         ST_LOOP_B: begin
            // h[i-1] = sat(acc - ai*y), start b(i+1) * s
            w.dp.coef_sel = CS_B_NEXT;
            w.dp.mul_en   = 1'b1;
            w.dp.h_write  = 1'b1;
            w.tap_inc     = 1'b1;
            w.accept      = ACC_LAST_TAP;
            w.cond        = CD_MORE_TAPS;
            w.jump_to     = ST_LOOP_A;
            w.next_step   = ST_IDLE;
         end
         ST_IDLE: begin
            w.accept    = ACC_ALWAYS;
            w.next_step = ST_IDLE;
         end
         default: begin
            w.next_step = ST_IDLE;
         end
      endcase
      return w;
   endfunction

   // clamp to a delay term
   function automatic logic signed [DELAY_W-1:0] sat_delay(
      input logic signed [ACC_W-1:0] v);
      logic [ACC_W-DELAY_W:0] top;
      logic signed [DELAY_W-1:0] r;
      top = v[ACC_W-1:DELAY_W-1];
      if (&top || ~|top) begin
         r = v[DELAY_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(DELAY_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DELAY_W-1){1'b1}}};
      end
      return r;
   endfunction

   // clamp to an output sample
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
      logic [ACC_W-SAMPLE_W:0] top;
      logic signed [SAMPLE_W-1:0] r;
      top = v[ACC_W-1:SAMPLE_W-1];
      if (&top || ~|top) begin
         r = v[SAMPLE_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

[design/iirtdf_useq.sv]
// Microcode sequencer of the IIR unit: step counter, tap counter, control store.
// Depends on iirtdf_pkg.
module iirtdf_useq #(
   parameter int ORDER = iirtdf_pkg::DEF_ORDER,
   localparam int TAP_W = (ORDER > 1) ? $clog2(ORDER) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     out_free,
   output logic                     req_ready,
   output iirtdf_pkg::dp_ctrl_type  ctrl,
   output logic [TAP_W-1:0]         tap,
   output logic                     last
);

   iirtdf_pkg::step_type  step_ff, step_in;
   iirtdf_pkg::ucode_type uc;
   logic [TAP_W-1:0]      tap_ff, tap_in;
   logic                  fire;
   logic                  stall;

   // control word fetch and step conditions
   always_comb begin
      uc        = iirtdf_pkg::ucode_rom(step_ff);
      last      = (tap_ff == TAP_W'(ORDER - 1));
      req_ready = (uc.accept == iirtdf_pkg::ACC_ALWAYS) ||
                  ((uc.accept == iirtdf_pkg::ACC_LAST_TAP) && last);
      fire      = req_valid && req_ready;
      stall     = (uc.cond == iirtdf_pkg::CD_STALL) && !out_free;
   end

   // next step: an accepted request restarts the program
   always_comb begin
      if (fire) begin
         step_in = iirtdf_pkg::ST_MUL0;
      end else begin
         unique case (uc.cond)
            iirtdf_pkg::CD_NONE:      step_in = uc.next_step;
            iirtdf_pkg::CD_STALL:     step_in = stall ? uc.jump_to : uc.next_step;
            iirtdf_pkg::CD_MORE_TAPS: step_in = last ? uc.next_step : uc.jump_to;
            default:                  step_in = iirtdf_pkg::ST_IDLE;
         endcase
      end
   end

   // datapath strobes, held off while the result register is busy
   always_comb begin
      ctrl = uc.dp;
      if (stall) begin
         ctrl.mul_en = 1'b0;
         ctrl.y_load = 1'b0;
      end
   end

   // tap counter
   always_comb begin
      if (uc.tap_clr) begin
         tap_in = '0;
      end else if (uc.tap_inc) begin
         tap_in = tap_ff + TAP_W'(1);
      end else begin
         tap_in = tap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= iirtdf_pkg::ST_IDLE;
         tap_ff  <= '0;
      end else begin
         step_ff <= step_in;
         tap_ff  <= tap_in;
      end
   end

   assign tap = tap_ff;

endmodule

[design/third_order_iir_tdf2_unit.sv]
// Top level of the third-order IIR filter (transposed direct form II).
// Depends on iirtdf_pkg and iirtdf_useq.
//
// Usage:
//   req_* carries one signed 24-bit sample and a block-end flag per request
//   (valid/ready). rsp_* returns the saturated filtered sample and the copied
//   flag (valid/ready). csr_* writes coefficient i (b0..bN, then a1..aN) when
//   csr_write_enable is high; indexes past the last one are ignored. Write
//   coefficients only while the unit is idle.
//   After a request is accepted, the b0 product step runs, then the output
//   step loads the response register. The one shared 32x24 multiplier forms
//   the 2*ORDER+1 products of a request in turn. The next request is taken in
//   the last step of the current one.
//   A response waits in an output register; a new request is still taken,
//   and its program holds at the output step until that register frees up.
//   Reset (synchronous): b0 = 1.0, other coefficients and delay terms zero,
//   no response pending. No clearing pass is needed.
module third_order_iir_tdf2_unit #(
   parameter int ORDER          = iirtdf_pkg::DEF_ORDER,
   parameter int COEF_FRAC_BITS = iirtdf_pkg::DEF_FRAC_BITS,
   localparam int NUM_REGS      = 2 * ORDER + 1,
   localparam int REG_IDX_W     = $clog2(NUM_REGS)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [iirtdf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                   req_block_end,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [iirtdf_pkg::SAMPLE_W-1:0] rsp_filtered,
   output logic                                   rsp_block_end_out,
   input  logic                                   csr_write_enable,
   input  logic [REG_IDX_W-1:0]                   csr_index,
   input  logic [iirtdf_pkg::COEF_W-1:0]          csr_data
);

   localparam int TAP_W = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam logic [iirtdf_pkg::COEF_W-1:0] B0_RESET =
      iirtdf_pkg::COEF_W'(1) << COEF_FRAC_BITS;

   iirtdf_pkg::dp_ctrl_type ctrl;
   logic [TAP_W-1:0]        tap;
   logic                    last;
   logic                    out_free;
   logic                    req_fire;

   logic signed [iirtdf_pkg::COEF_W-1:0]   coef_ff [NUM_REGS];
   logic signed [iirtdf_pkg::DELAY_W-1:0]  h_ff [ORDER];
   logic signed [iirtdf_pkg::SAMPLE_W-1:0] s_ff, y_ff;
   logic                                   be_ff;
   logic signed [iirtdf_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [iirtdf_pkg::ACC_W-1:0]    acc_ff;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [iirtdf_pkg::SAMPLE_W-1:0] rsp_filtered_ff;
   logic                                   rsp_be_ff;

   logic [REG_IDX_W:0]                     tap_ext, coef_addr;
   logic signed [iirtdf_pkg::COEF_W-1:0]   coef_rd;
   logic signed [iirtdf_pkg::SAMPLE_W-1:0] mul_opnd;
   logic signed [iirtdf_pkg::PROD_W-1:0]   prod_shift;
   logic signed [iirtdf_pkg::ACC_W-1:0]    term, base, sum, diff;
   logic [TAP_W-1:0]                       h_idx;

   iirtdf_useq #(
      .ORDER (ORDER)
   ) u_useq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctrl      (ctrl),
      .tap       (tap),
      .last      (last)
   );

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // coefficient select and multiplier operands
   always_comb begin
      tap_ext = (REG_IDX_W + 1)'(tap);
      case (ctrl.coef_sel)
         iirtdf_pkg::CS_B0:     coef_addr = '0;
         iirtdf_pkg::CS_B_TAP:  coef_addr = tap_ext + (REG_IDX_W + 1)'(1);
         iirtdf_pkg::CS_B_NEXT: coef_addr = tap_ext + (REG_IDX_W + 1)'(2);
         iirtdf_pkg::CS_A_TAP:  coef_addr = tap_ext + (REG_IDX_W + 1)'(ORDER + 1);
         default:               coef_addr = '0;
      endcase
      coef_rd  = coef_ff[coef_addr[REG_IDX_W-1:0]];
      mul_opnd = ctrl.mul_y ? y_ff : s_ff;
      prod_in  = coef_rd * mul_opnd;
   end

   // shared adder: output sum at the output step, h[i] + bi*s in the loop
   always_comb begin
      prod_shift = prod_ff >>> COEF_FRAC_BITS;
      term       = iirtdf_pkg::ACC_W'(prod_shift);
      h_idx      = (ctrl.y_load || last) ? '0 : tap + TAP_W'(1);
      base       = (ctrl.acc_load && last) ? '0 : iirtdf_pkg::ACC_W'(h_ff[h_idx]);
      sum        = base + term;
      diff       = acc_ff - term;
   end

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= (i == 0) ? B0_RESET : '0;
         end
      end else if (csr_write_enable &&
                   ({1'b0, csr_index} < (REG_IDX_W + 1)'(NUM_REGS))) begin
         coef_ff[csr_index] <= csr_data;
      end
   end

   // delay terms
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ORDER; i++) begin
            h_ff[i] <= '0;
         end
      end else if (ctrl.h_write) begin
         h_ff[tap] <= iirtdf_pkg::sat_delay(diff);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s_ff  <= req_sample;
         be_ff <= req_block_end;
      end
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc_load) begin
         acc_ff <= sum;
      end
      if (ctrl.y_load) begin
         y_ff            <= iirtdf_pkg::sat_sample(sum);
         rsp_filtered_ff <= iirtdf_pkg::sat_sample(sum);
         rsp_be_ff       <= be_ff;
      end
   end

   // response register
   always_comb begin
      if (ctrl.y_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered      = rsp_filtered_ff;
   assign rsp_block_end_out = rsp_be_ff;

endmodule

[design/iirtdf_checker.sv]
// Port-level checks of the third-order IIR unit, bound to its top level.
// Depends on iirtdf_pkg and third_order_iir_tdf2_unit_macros.svh.
`include "third_order_iir_tdf2_unit_macros.svh"

module iirtdf_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [iirtdf_pkg::SAMPLE_W-1:0] rsp_filtered,
   input logic                                   rsp_block_end_out
);

   // a stalled response holds
   `IIRTDF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_filtered) && $stable(rsp_block_end_out), "response changed while stalled")

   // the unit is busy right after taking a request
   `IIRTDF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken on consecutive cycles")

   // a new response only comes out of a busy program
   `IIRTDF_ASSERT_SAME(a_rsp_from_work, clock, reset, $rose(rsp_valid), !$past(req_ready), "response appeared while idle")

   // reset leaves the unit idle and empty
   `IIRTDF_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, !rsp_valid && req_ready, "unit not idle after reset")

endmodule

bind third_order_iir_tdf2_unit iirtdf_checker u_checker (.*);

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench for third_order_iir_tdf2_unit: streams samples under several coefficient sets,
// predicts every filtered sample and checks the responses in order.
// Depends on iirtdf_pkg and the unit itself.
module tb;

   localparam int TAPS            = iirtdf_pkg::DEF_ORDER;
   localparam int FRAC            = iirtdf_pkg::DEF_FRAC_BITS;
   localparam int SW              = iirtdf_pkg::SAMPLE_W;
   localparam int CW              = iirtdf_pkg::COEF_W;
   localparam int NUM_IDX         = 8;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int DRAIN_CYCLES    = 12;
   localparam int MAX_PRINTED     = 40;

   localparam logic [SW-1:0] SAMPLE_TOP = {1'b0, {(SW-1){1'b1}}};
   localparam logic [SW-1:0] SAMPLE_BOT = {1'b1, {(SW-1){1'b0}}};
   localparam logic [CW-1:0] COEF_TOP   = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] COEF_BOT   = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0] COEF_ONE   = 32'h1000_0000;

   localparam longint OUT_MAX   = (64'sd1 <<< (SW - 1)) - 1;
   localparam longint OUT_MIN   = -(64'sd1 <<< (SW - 1));
   localparam longint DELAY_MAX = (64'sd1 <<< 47) - 1;
   localparam longint DELAY_MIN = -(64'sd1 <<< 47);

   // coefficient register map; the last index is past the end and is ignored
   typedef enum logic [2:0] {
      REG_B0, REG_B1, REG_B2, REG_B3, REG_A1, REG_A2, REG_A3, REG_SPARE
   } coef_reg_type;

   typedef struct packed {
      logic signed [SW-1:0] filtered;
      logic                 block_end;
   } filter_out_type;

   // filter state mirror plus the queue of filtered samples still owed
   class tone_stack_tracker;
      longint         fwd[0:TAPS];
      longint         fbk[1:TAPS];
      longint         delay[0:TAPS-1];
      filter_out_type pending_outputs[$];
      int             error_count;

      function new();
         for (int i = 0; i <= TAPS; i++) fwd[i] = 0;
         for (int i = 1; i <= TAPS; i++) fbk[i] = 0;
         for (int i = 0; i < TAPS; i++) delay[i] = 0;
         fwd[0] = longint'(1) <<< FRAC;
         error_count = 0;
      endfunction

      function void set_coef(coef_reg_type idx, logic [CW-1:0] data);
         longint v;
         int     n;
         v = $signed(data);
         n = int'(idx);
         if (n <= TAPS) begin
            fwd[n] = v;
         end else if (n <= 2 * TAPS) begin
            fbk[n - TAPS] = v;
         end
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      // one transposed direct form II step; products floor-shifted by FRAC
      function void note_request(logic signed [SW-1:0] s, logic be);
         longint         sv;
         longint         y;
         filter_out_type r;
         sv = s;
         y = clamp(delay[0] + ((fwd[0] * sv) >>> FRAC), OUT_MIN, OUT_MAX);
         for (int i = 1; i < TAPS; i++) begin
            delay[i-1] = clamp(delay[i] + ((fwd[i] * sv) >>> FRAC)
                               - ((fbk[i] * y) >>> FRAC), DELAY_MIN, DELAY_MAX);
         end
         delay[TAPS-1] = clamp(((fwd[TAPS] * sv) >>> FRAC)
                               - ((fbk[TAPS] * y) >>> FRAC), DELAY_MIN, DELAY_MAX);
         r.filtered  = y[SW-1:0];
         r.block_end = be;
         pending_outputs.push_back(r);
      endfunction

      task report_mismatch(string msg);
         error_count++;
         if (error_count <= MAX_PRINTED) $display("MISMATCH: %s", msg);
      endtask

      task check_response(logic signed [SW-1:0] f, logic be);
         filter_out_type exp_out;
         if (pending_outputs.size() == 0) begin
            report_mismatch($sformatf("response %0d with no request outstanding", f));
         end else begin
            exp_out = pending_outputs.pop_front();
            if (f !== exp_out.filtered)
               report_mismatch($sformatf("filtered got %0d exp %0d", f, exp_out.filtered));
            if (be !== exp_out.block_end)
               report_mismatch($sformatf("block_end_out got %b exp %b", be,
                                         exp_out.block_end));
         end
      endtask

      task flag_leftovers();
         if (pending_outputs.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", pending_outputs.size()));
      endtask

      function int pending();
         return pending_outputs.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [SW-1:0] req_sample;
   logic                 req_block_end;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [SW-1:0] rsp_filtered;
   logic                 rsp_block_end_out;
   logic                 csr_write_enable;
   logic [2:0]           csr_index;
   logic [CW-1:0]        csr_data;

   tone_stack_tracker tracker = new();
   logic [CW-1:0]     coef_set[0:NUM_IDX-1];
   bit                idle_on = 1'b1;
   bit                hold_off_req = 1'b0;
   int                cycle_count = 0;

   third_order_iir_tdf2_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_block_end     (req_block_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filtered      (rsp_filtered),
      .rsp_block_end_out (rsp_block_end_out),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("third_order_iir_tdf2_unit test failed");
      $finish;
   end

   // response side: check, then pick next ready (long hold-off, bursts, or open)
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            tracker.check_response(rsp_filtered, rsp_block_end_out);
         if (hold_off_req) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one request and hold it until taken; sometimes idle afterwards
   task automatic send_request(input logic [SW-1:0] s, input logic be);
      req_valid     <= 1'b1;
      req_sample    <= s;
      req_block_end <= be;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(s, be);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // mix of rail values, small audio-like values and full-range noise
   task automatic send_random(input int count);
      logic [SW-1:0] s;
      int            pick;
      int            tmp;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: s = SAMPLE_TOP;
            1: s = SAMPLE_BOT;
            2, 3, 4: begin
               tmp = $urandom_range(0, 4000);
               tmp = tmp - 2000;
               s   = tmp[SW-1:0];
            end
            default: s = SW'($urandom);
         endcase
         send_request(s, $urandom_range(0, 15) == 0);
      end
   endtask

   // write all indexes, the unused one included
   task automatic load_coefs();
      for (int i = 0; i < NUM_IDX; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= coef_reg_type'(i);
         csr_data         <= coef_set[i];
         @(posedge clock);
         tracker.set_coef(coef_reg_type'(i), coef_set[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   // let every owed response arrive, then give the sequencer time to settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int tmp;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_sample       <= '0;
      req_block_end    <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= REG_B0;
      csr_data         <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset coefficients: pass-through, rails and block-end flag
      send_request('0, 1'b0);
      send_request(24'd1, 1'b0);
      send_request('1, 1'b1);
      send_request(SAMPLE_TOP, 1'b0);
      send_request(SAMPLE_BOT, 1'b1);
      send_request(SAMPLE_TOP, 1'b0);
      send_request(SAMPLE_BOT, 1'b0);
      send_request('0, 1'b1);
      wait_drained();

      // extreme coefficients: output saturation both ways
      coef_set[REG_B0] = COEF_TOP;
      coef_set[REG_B1] = COEF_BOT;
      coef_set[REG_B2] = COEF_TOP;
      coef_set[REG_B3] = COEF_BOT;
      coef_set[REG_A1] = COEF_TOP;
      coef_set[REG_A2] = COEF_BOT;
      coef_set[REG_A3] = COEF_TOP;
      coef_set[REG_SPARE] = $urandom;
      load_coefs();
      send_request(SAMPLE_TOP, 1'b0);
      send_request(SAMPLE_TOP, 1'b1);
      send_request(SAMPLE_BOT, 1'b0);
      send_request(SAMPLE_BOT, 1'b0);
      send_request('0, 1'b0);
      send_request(24'd1, 1'b1);
      send_request('1, 1'b0);
      send_request(SAMPLE_TOP, 1'b0);
      wait_drained();

      // stable low-pass set, with a long response hold-off
      coef_set[REG_B0] = 32'h0400_0000;
      coef_set[REG_B1] = 32'h0800_0000;
      coef_set[REG_B2] = 32'h0400_0000;
      coef_set[REG_B3] = 32'h0100_0000;
      coef_set[REG_A1] = -32'sd241591910;
      coef_set[REG_A2] = 32'sd80530637;
      coef_set[REG_A3] = -32'sd13421773;
      coef_set[REG_SPARE] = $urandom;
      load_coefs();
      hold_off_req = 1'b1;
      send_random(200);
      wait_drained();

      // full-range random coefficients
      for (int i = 0; i < NUM_IDX; i++) coef_set[i] = $urandom;
      load_coefs();
      send_random(150);
      wait_drained();

      // all coefficients at the negative rail
      for (int i = 0; i < NUM_IDX; i++) coef_set[i] = COEF_BOT;
      load_coefs();
      send_random(100);
      wait_drained();

      // moderate random coefficients within +/-1.0, hold-off again
      for (int i = 0; i < NUM_IDX; i++) begin
         tmp = $urandom_range(0, 2 * COEF_ONE);
         coef_set[i] = tmp - COEF_ONE;
      end
      load_coefs();
      hold_off_req = 1'b1;
      send_random(200);
      wait_drained();

      // final stretch without idling on either side
      for (int i = 0; i < NUM_IDX; i++) coef_set[i] = $urandom;
      coef_set[REG_B0] = COEF_ONE;
      load_coefs();
      idle_on = 1'b0;
      send_random(200);
      wait_drained();

      tracker.flag_leftovers();
      if (tracker.error_count == 0) begin
         $display("third_order_iir_tdf2_unit test passed");
      end else begin
         $display("third_order_iir_tdf2_unit test failed");
      end
      $finish;
   end

endmodule
